// ===== hdl/qslerp_pkg.sv =====
`default_nettype none
package qslerp_pkg;
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int INNER_BITS = 30;
    localparam logic [63:0] INNER_ONE = 64'd1 << INNER_BITS;
    localparam logic signed [63:0] CORDIC_GAIN_INV = 64'sd652032874;
    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    function automatic logic signed [63:0] atan_entry(input logic [4:0] i);
        logic signed [63:0] r;
        begin
            case (i)
                5'd0: r = 64'sh3243F6A8;
                5'd1: r = 64'sh1DAC6705;
                5'd2: r = 64'sh0FADBAFC;
                5'd3: r = 64'sh07F56EA6;
                5'd4: r = 64'sh03FEAB76;
                5'd5: r = 64'sh01FFD55B;
                5'd6: r = 64'sh00FFFAAA;
                5'd7: r = 64'sh007FFF55;
                5'd8: r = 64'sh003FFFEA;
                5'd9: r = 64'sh001FFFFD;
                5'd10: r = 64'sh000FFFFF;
                5'd11: r = 64'sh0007FFFF;
                5'd12: r = 64'sh0003FFFF;
                5'd13: r = 64'sh0001FFFF;
                5'd14: r = 64'sh0000FFFF;
                5'd15: r = 64'sh00007FFF;
                5'd16: r = 64'sh00003FFF;
                5'd17: r = 64'sh00001FFF;
                5'd18: r = 64'sh00000FFF;
                5'd19: r = 64'sh000007FF;
                5'd20: r = 64'sh000003FF;
                5'd21: r = 64'sh000001FF;
                5'd22: r = 64'sh000000FF;
                5'd23: r = 64'sh0000007F;
                5'd24: r = 64'sh0000003F;
                5'd25: r = 64'sh0000001F;
                5'd26: r = 64'sh0000000F;
                5'd27: r = 64'sh00000008;
                5'd28: r = 64'sh00000004;
                5'd29: r = 64'sh00000002;
                5'd30: r = 64'sh00000001;
                default: r = 64'sh0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== hdl/qslerp_front.sv =====
`default_nettype none
// Classify: equality test, dot product, fold sign, clamp fraction, path choice.
module qslerp_front #(
    parameter int CW = qslerp_pkg::COMPONENT_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [8*CW-1:0]      in_q,
    input  wire logic [CW-2:0]        in_frac,
    input  wire logic [CW-2:0]        threshold,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [8*CW-1:0]           out_q,
    output logic [CW-1:0]             out_frac,
    output logic [CW-1:0]             out_dot,
    output logic                      out_neg,
    output logic [1:0]                out_kind
);
    import qslerp_pkg::*;
    localparam int F = CW - 2;
    localparam logic [CW-1:0] UNIT = CW'(1) << F;

    logic s1_valid_reg;
    logic [8*CW-1:0] s1_q_reg;
    logic [CW-1:0] s1_frac_reg;
    logic signed [2*CW+2:0] s1_dot_reg;
    logic s1_same_reg;
    logic adv1, adv2;
    logic signed [2*CW+2:0] dot_next;
    logic signed [2*CW-1:0] prod;
    logic signed [2*CW+2:0] d_cl;
    logic [CW-1:0] d_abs;
    logic neg;
    logic signed [CW+1:0] one_minus;

    always_comb begin
        dot_next = '0;
        for (int k = 0; k < 4; k++) begin
            prod = $signed(in_q[k*CW +: CW]) * $signed(in_q[(4+k)*CW +: CW]);
            dot_next = dot_next + ((2*CW+3)'(prod >>> F));
        end
    end

    assign adv2 = !out_valid || out_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv1) begin
            s1_valid_reg <= in_valid;
        end
        if (adv1 && in_valid) begin
            s1_q_reg <= in_q;
            s1_frac_reg <= ({1'b0, in_frac} > UNIT) ? UNIT : {1'b0, in_frac};
            s1_dot_reg <= dot_next;
            s1_same_reg <= in_q[4*CW-1:0] == in_q[8*CW-1:4*CW];
        end
    end

    always_comb begin
        d_cl = (s1_dot_reg > $signed({{(CW+3){1'b0}}, UNIT})) ?
            $signed({{(CW+3){1'b0}}, UNIT}) : s1_dot_reg;
        neg = d_cl < 0;
        d_abs = neg ? CW'(-d_cl) : CW'(d_cl);
        // dot below -1 leaves 1-dot negative: linear
        one_minus = $signed({2'b0, UNIT}) - (neg ? -(CW+2)'(d_cl) : (CW+2)'(d_cl));
        if (neg && d_cl < -$signed({{(CW+3){1'b0}}, UNIT})) one_minus = -1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (adv2) begin
            out_valid <= s1_valid_reg;
        end
        if (adv2 && s1_valid_reg) begin
            // second quaternion travels raw; the back end applies the sign fold
            out_q <= s1_q_reg;
            out_frac <= s1_frac_reg;
            out_dot <= d_abs;
            out_neg <= neg && !s1_same_reg;
            if (s1_same_reg) out_kind <= 2'd0;
            else if (one_minus > $signed({3'b0, threshold})) out_kind <= 2'd2;
            else out_kind <= 2'd1;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/qslerp_fifo.sv =====
`default_nettype none
module qslerp_fifo #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);
    logic [W-1:0] mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic push, pop;
    assign in_ready = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign out_data = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
        if (push) mem_reg[wr_reg] <= in_data;
    end
endmodule
`default_nettype wire

// ===== hdl/qslerp_back.sv =====
`default_nettype none
// Pipeline: sqrt (bit-pair stages), atan2 CORDIC, part angles, sine CORDIC,
// radix-2 dividers, weight select, blend. Each stage holds under downstream stall.
module qslerp_back #(
    parameter int CW = qslerp_pkg::COMPONENT_WIDTH_DEF,
    parameter int NS = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [8*CW-1:0] in_q,
    input  wire logic [CW-1:0]   in_frac,
    input  wire logic [CW-1:0]   in_dot,
    input  wire logic            in_neg,
    input  wire logic [1:0]      in_kind,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [4*CW-1:0]      out_q
);
    import qslerp_pkg::*;
    localparam int F = CW - 2;
    localparam int SH = INNER_BITS - F;
    localparam int SQ = 31;
    localparam int NCS = (NS < 32) ? NS : 32;
    localparam int DV = 31;
    localparam int NST = SQ + NCS + 1 + NCS + DV + 2;
    localparam logic [CW-1:0] UNIT = CW'(1) << F;

    typedef struct packed {
        logic [8*CW-1:0] q;
        logic [CW-1:0] frac;
        logic [1:0] kind;
        logic neg;
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] z;
        logic signed [63:0] sx0;
        logic signed [63:0] sy0;
        logic signed [63:0] z0;
        logic signed [63:0] sx1;
        logic signed [63:0] sy1;
        logic signed [63:0] z1;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] c;
        logic [63:0] n0;
        logic [63:0] n1;
        logic [63:0] r0;
        logic [63:0] r1;
        logic [31:0] q0;
        logic [31:0] q1;
    } stage_t;

    logic [NST:0] v_reg;
    stage_t s_reg [NST+1];
    stage_t s_next [NST+1];
    logic [NST:0] adv;

    always_comb begin
        adv[NST] = !v_reg[NST] || out_ready;
        for (int i = NST - 1; i >= 0; i--) adv[i] = !v_reg[i] || adv[i+1];
    end
    assign in_ready = adv[0];

    always_comb begin
        logic [63:0] d, bitv, trial;
        logic signed [63:0] nx, ny, a, pa0, pa1, w0, w1, acc, r, qb;
        logic [63:0] t0, t1;
        int j;
        for (int i = 0; i <= NST; i++) s_next[i] = '0;
        // stage 0: load
        d = 64'(in_dot) << SH;
        s_next[0].q = in_q;
        s_next[0].frac = in_frac;
        s_next[0].kind = in_kind;
        s_next[0].neg = in_neg;
        s_next[0].rem = INNER_ONE * INNER_ONE - d * d;
        s_next[0].root = '0;
        s_next[0].cx = $signed(d);
        for (int i = 1; i <= SQ; i++) begin
            s_next[i] = s_reg[i-1];
            bitv = 64'd1 << (2 * (SQ - i));
            trial = s_reg[i-1].root + bitv;
            if (s_reg[i-1].rem >= trial) begin
                s_next[i].rem = s_reg[i-1].rem - trial;
                s_next[i].root = (s_reg[i-1].root >> 1) + bitv;
            end else begin
                s_next[i].root = s_reg[i-1].root >> 1;
            end
            if (i == SQ) begin
                s_next[i].c = s_next[i].root;
                s_next[i].cy = $signed(s_next[i].root);
                s_next[i].z = '0;
            end
        end
        for (int i = 0; i < NCS; i++) begin
            j = SQ + 1 + i;
            s_next[j] = s_reg[j-1];
            if (s_reg[j-1].cy >= 0) begin
                nx = s_reg[j-1].cx + (s_reg[j-1].cy >>> i);
                ny = s_reg[j-1].cy - (s_reg[j-1].cx >>> i);
                s_next[j].z = s_reg[j-1].z + atan_entry(5'(i));
            end else begin
                nx = s_reg[j-1].cx - (s_reg[j-1].cy >>> i);
                ny = s_reg[j-1].cy + (s_reg[j-1].cx >>> i);
                s_next[j].z = s_reg[j-1].z - atan_entry(5'(i));
            end
            s_next[j].cx = nx;
            s_next[j].cy = ny;
        end
        j = SQ + NCS + 1;
        s_next[j] = s_reg[j-1];
        a = (s_reg[j-1].z < 0) ? 64'sd0 : s_reg[j-1].z;
        pa0 = (a * $signed({48'd0, UNIT - s_reg[j-1].frac})) >>> F;
        pa1 = (a * $signed({48'd0, s_reg[j-1].frac})) >>> F;
        s_next[j].z0 = pa0;
        s_next[j].z1 = pa1;
        s_next[j].sx0 = CORDIC_GAIN_INV;
        s_next[j].sx1 = CORDIC_GAIN_INV;
        s_next[j].sy0 = '0;
        s_next[j].sy1 = '0;
        for (int i = 0; i < NCS; i++) begin
            j = SQ + NCS + 2 + i;
            s_next[j] = s_reg[j-1];
            if (s_reg[j-1].z0 >= 0) begin
                s_next[j].sx0 = s_reg[j-1].sx0 - (s_reg[j-1].sy0 >>> i);
                s_next[j].sy0 = s_reg[j-1].sy0 + (s_reg[j-1].sx0 >>> i);
                s_next[j].z0 = s_reg[j-1].z0 - atan_entry(5'(i));
            end else begin
                s_next[j].sx0 = s_reg[j-1].sx0 + (s_reg[j-1].sy0 >>> i);
                s_next[j].sy0 = s_reg[j-1].sy0 - (s_reg[j-1].sx0 >>> i);
                s_next[j].z0 = s_reg[j-1].z0 + atan_entry(5'(i));
            end
            if (s_reg[j-1].z1 >= 0) begin
                s_next[j].sx1 = s_reg[j-1].sx1 - (s_reg[j-1].sy1 >>> i);
                s_next[j].sy1 = s_reg[j-1].sy1 + (s_reg[j-1].sx1 >>> i);
                s_next[j].z1 = s_reg[j-1].z1 - atan_entry(5'(i));
            end else begin
                s_next[j].sx1 = s_reg[j-1].sx1 + (s_reg[j-1].sy1 >>> i);
                s_next[j].sy1 = s_reg[j-1].sy1 - (s_reg[j-1].sx1 >>> i);
                s_next[j].z1 = s_reg[j-1].z1 + atan_entry(5'(i));
            end
            if (i == NCS - 1) begin
                // clamp sines to [0, 1]; a sine above c saturates the weight,
                // so cap it at c and keep the quotient within 2^30
                s_next[j].n0 = (s_next[j].sy0 < 0) ? 64'd0 :
                    ((s_next[j].sy0 > $signed(INNER_ONE)) ? INNER_ONE : s_next[j].sy0);
                s_next[j].n1 = (s_next[j].sy1 < 0) ? 64'd0 :
                    ((s_next[j].sy1 > $signed(INNER_ONE)) ? INNER_ONE : s_next[j].sy1);
                s_next[j].r0 = (s_next[j].n0 > s_next[j].c) ? s_next[j].c : s_next[j].n0;
                s_next[j].r1 = (s_next[j].n1 > s_next[j].c) ? s_next[j].c : s_next[j].n1;
                s_next[j].q0 = '0;
                s_next[j].q1 = '0;
            end
        end
        // restoring divide of (n << 30) by c with n <= c, quotient bit 30 first
        for (int i = 0; i < DV; i++) begin
            j = SQ + 2 * NCS + 2 + i;
            s_next[j] = s_reg[j-1];
            t0 = s_reg[j-1].r0;
            t1 = s_reg[j-1].r1;
            if (t0 >= s_reg[j-1].c && s_reg[j-1].c != 0) begin
                s_next[j].r0 = (t0 - s_reg[j-1].c) << 1;
                s_next[j].q0 = {s_reg[j-1].q0[30:0], 1'b1};
            end else begin
                s_next[j].r0 = t0 << 1;
                s_next[j].q0 = {s_reg[j-1].q0[30:0], 1'b0};
            end
            if (t1 >= s_reg[j-1].c && s_reg[j-1].c != 0) begin
                s_next[j].r1 = (t1 - s_reg[j-1].c) << 1;
                s_next[j].q1 = {s_reg[j-1].q1[30:0], 1'b1};
            end else begin
                s_next[j].r1 = t1 << 1;
                s_next[j].q1 = {s_reg[j-1].q1[30:0], 1'b0};
            end
        end
        // weight select
        j = SQ + 2 * NCS + 2 + DV;
        s_next[j] = s_reg[j-1];
        w0 = $signed(64'(UNIT - s_reg[j-1].frac) << SH);
        w1 = $signed(64'(s_reg[j-1].frac) << SH);
        if (s_reg[j-1].kind == 2'd2 && s_reg[j-1].c != 0) begin
            w0 = (s_reg[j-1].q0 > 32'(INNER_ONE)) ? $signed(INNER_ONE) :
                $signed({32'd0, s_reg[j-1].q0});
            w1 = (s_reg[j-1].q1 > 32'(INNER_ONE)) ? $signed(INNER_ONE) :
                $signed({32'd0, s_reg[j-1].q1});
        end
        s_next[j].sx0 = w0;
        s_next[j].sx1 = w1;
        // blend; negate the second quaternion at full width for a negative dot
        j = NST;
        s_next[j] = s_reg[j-1];
        for (int k = 0; k < 4; k++) begin
            qb = 64'($signed(s_reg[j-1].q[(4+k)*CW +: CW]));
            if (s_reg[j-1].neg) qb = -qb;
            acc = s_reg[j-1].sx0 * 64'($signed(s_reg[j-1].q[k*CW +: CW]))
                + s_reg[j-1].sx1 * qb;
            r = (acc + $signed(INNER_ONE >> 1)) >>> INNER_BITS;
            if (r > $signed(64'(UNIT))) r = $signed(64'(UNIT));
            if (r < -$signed(64'(UNIT))) r = -$signed(64'(UNIT));
            s_next[j].q[k*CW +: CW] = (s_reg[j-1].kind == 2'd0) ?
                s_reg[j-1].q[k*CW +: CW] : CW'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int i = 1; i <= NST; i++) if (adv[i]) v_reg[i] <= v_reg[i-1];
        end
        if (adv[0] && in_valid) s_reg[0] <= s_next[0];
        for (int i = 1; i <= NST; i++)
            if (adv[i] && v_reg[i-1]) s_reg[i] <= s_next[i];
    end

    assign out_valid = v_reg[NST];
    assign out_q = s_reg[NST].q[4*CW-1:0];
endmodule
`default_nettype wire

// ===== hdl/quaternion_slerp_core.sv =====
`default_nettype none
// channel   | dir | payload
// s_axis    | in  | first xyzw, second xyzw, fraction (tdata)
// m_axis    | out | blend xyzw (tdata)
// apb       | in  | linear_threshold at address 0
// One item per cycle sustained while m_axis is ready. The path holds 2 front-end
// stages, 1 in the queue and 98 back-end stages, set by the square root,
// two CORDIC chains, the divider stages and the load, angle, weight and blend stages.
// Reset is synchronous and clears all valid bits and the queue.
// A stall on m_axis backs up through the pipeline, queue, then front end.
module quaternion_slerp_core #(
    parameter int COMPONENT_WIDTH = qslerp_pkg::COMPONENT_WIDTH_DEF,
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // first_x..w, second_x..w, fraction (lowest first)
    input  wire logic [((9*COMPONENT_WIDTH-1+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // blend_x, blend_y, blend_z, blend_w
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import qslerp_pkg::*;
    localparam int CW = COMPONENT_WIDTH;
    localparam int QW = 8 * CW + CW + 1 + CW + 2;
    localparam logic [CW-2:0] THR_RESET = (CW-1)'(((1 << (CW - 2)) + 50) / 100);

    logic [CW-2:0] thr_reg;
    logic fv, fr, qv, qr;
    logic [8*CW-1:0] fq;
    logic [CW-1:0] ffrac, fdot;
    logic fneg;
    logic [1:0] fkind;
    logic [QW-1:0] qout;
    logic [4*CW-1:0] bq;

    assign pready = 1'b1;
    assign prdata = 32'(thr_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD) begin
            thr_reg <= pwdata[CW-2:0];
        end
    end

    qslerp_front #(.CW(CW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_q(s_tdata[8*CW-1:0]), .in_frac(s_tdata[9*CW-2:8*CW]),
        .threshold(thr_reg),
        .out_valid(fv), .out_ready(fr),
        .out_q(fq), .out_frac(ffrac), .out_dot(fdot), .out_neg(fneg),
        .out_kind(fkind)
    );

    qslerp_fifo #(.W(QW)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fv), .in_ready(fr), .in_data({fneg, fkind, fdot, ffrac, fq}),
        .out_valid(qv), .out_ready(qr), .out_data(qout)
    );

    qslerp_back #(.CW(CW), .NS(CORDIC_STEPS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(qv), .in_ready(qr),
        .in_q(qout[8*CW-1:0]), .in_frac(qout[9*CW-1:8*CW]),
        .in_dot(qout[10*CW-1:9*CW]), .in_neg(qout[10*CW+2]),
        .in_kind(qout[10*CW+1:10*CW]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_q(bq)
    );

    assign m_tdata = {{(((4*CW+7)/8)*8-4*CW){1'b0}}, bq};
endmodule
`default_nettype wire
